FILE: rtl/dsst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsst_pkg: shared types and constants of the diagnostic session keeper
// command and session codes, register indexes, reset values, word types
// ----------------------------------------------------------------------------
package dsst_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int CFG_WIDTH      = 16;
  localparam int CFG_ADDR_WIDTH = 2;

  // command codes
  localparam logic [2:0] CMD_TICK        = 3'd0;
  localparam logic [2:0] CMD_SET_SESSION = 3'd1;
  localparam logic [2:0] CMD_FAIL_UNLOCK = 3'd2;
  localparam logic [2:0] CMD_ECU_RESET   = 3'd3;
  localparam logic [2:0] CMD_WRITE_FLAG  = 3'd4;

  // session codes
  localparam logic [1:0] SES_STD    = 2'd0;
  localparam logic [1:0] SES_EOL    = 2'd1;
  localparam logic [1:0] SES_CODING = 2'd2;
  localparam logic [1:0] SES_PROG   = 2'd3;

  // response codes
  localparam logic RSP_OK            = 1'b0;
  localparam logic RSP_NOT_SUPPORTED = 1'b1;

  // register indexes
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_SESSION_TIMEOUT = 2'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_SECURITY_DELAY  = 2'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_MAX_INVALID     = 2'd2;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_RESET_DELAY     = 2'd3;

  // register reset values
  localparam logic [15:0] SESSION_TIMEOUT_RST = 16'd5000;
  localparam logic [15:0] SECURITY_DELAY_RST  = 16'd1000;
  localparam logic [7:0]  MAX_INVALID_RST     = 8'd3;
  localparam logic [15:0] RESET_DELAY_RST     = 16'd10;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] requested_session;
    logic       flag_value;
  } item_t;

  typedef struct packed {
    logic       reply_code;
    logic [1:0] session;
    logic       access_delayed;
    logic       reset_request_flag;
    logic       prog_request_pending;
    logic       reset_due;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/dsst_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsst_core: session, security delay and reset countdown state
// holds the registers and state, computes one result per step
// ----------------------------------------------------------------------------
module dsst_core #(
  parameter int TIMER_BITS = dsst_pkg::TIMER_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [dsst_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
  input  wire logic [dsst_pkg::CFG_WIDTH-1:0]      cfg_wdata,
  input  wire logic                                step,
  input  wire dsst_pkg::item_t                     item,
  output dsst_pkg::result_t                        result
);

  logic [15:0] session_timeout_r;
  logic [15:0] security_delay_r;
  logic [7:0]  max_invalid_r;
  logic [15:0] reset_delay_r;

  logic [1:0]            session_r, session_nxt;
  logic [TIMER_BITS-1:0] session_timer_r, session_timer_nxt;
  logic [7:0]            fail_count_r, fail_count_nxt;
  logic [TIMER_BITS-1:0] delay_timer_r, delay_timer_nxt;
  logic                  delay_flag_r, delay_flag_nxt;
  logic                  reset_armed_r, reset_armed_nxt;
  logic [TIMER_BITS-1:0] reset_timer_r, reset_timer_nxt;
  logic                  reset_flag_r, reset_flag_nxt;
  logic                  prog_flag_r, prog_flag_nxt;
  logic                  rsp;
  logic                  due;

  always_comb begin
    logic [7:0] fail_inc;
    session_nxt       = session_r;
    session_timer_nxt = session_timer_r;
    fail_count_nxt    = fail_count_r;
    delay_timer_nxt   = delay_timer_r;
    delay_flag_nxt    = delay_flag_r;
    reset_armed_nxt   = reset_armed_r;
    reset_timer_nxt   = reset_timer_r;
    reset_flag_nxt    = reset_flag_r;
    prog_flag_nxt     = prog_flag_r;
    rsp               = dsst_pkg::RSP_OK;
    due               = 1'b0;
    fail_inc          = (fail_count_r < max_invalid_r) ? fail_count_r + 8'd1 : fail_count_r;
    case (item.command)
      dsst_pkg::CMD_TICK: begin
        if (delay_timer_r != '0) begin
          delay_timer_nxt = delay_timer_r - TIMER_BITS'(1);
          if (delay_timer_r == TIMER_BITS'(1)) begin
            fail_count_nxt = 8'd0;
            delay_flag_nxt = 1'b0;
          end
        end
        if (session_r != dsst_pkg::SES_STD) begin
          if (session_timer_r == '0) begin
            session_nxt       = dsst_pkg::SES_STD;
            session_timer_nxt = TIMER_BITS'(session_timeout_r);
          end else begin
            session_timer_nxt = session_timer_r - TIMER_BITS'(1);
          end
        end
        if (reset_armed_r && (reset_timer_r != '0)) begin
          reset_timer_nxt = reset_timer_r - TIMER_BITS'(1);
          due = (reset_timer_r == TIMER_BITS'(1));
        end
      end
      dsst_pkg::CMD_SET_SESSION: begin
        if (item.requested_session != dsst_pkg::SES_PROG) begin
          session_nxt = item.requested_session;
        end else if (session_r != dsst_pkg::SES_CODING) begin
          prog_flag_nxt  = 1'b1;
          reset_flag_nxt = 1'b1;
        end else begin
          rsp = dsst_pkg::RSP_NOT_SUPPORTED;
        end
      end
      dsst_pkg::CMD_FAIL_UNLOCK: begin
        fail_count_nxt = fail_inc;
        if (fail_inc >= max_invalid_r) begin
          delay_flag_nxt  = 1'b1;
          delay_timer_nxt = TIMER_BITS'(security_delay_r);
        end
      end
      dsst_pkg::CMD_ECU_RESET: begin
        reset_armed_nxt = 1'b1;
        reset_timer_nxt = TIMER_BITS'(reset_delay_r);
      end
      dsst_pkg::CMD_WRITE_FLAG: begin
        reset_flag_nxt = item.flag_value;
      end
      default: begin
      end
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_timeout_r <= dsst_pkg::SESSION_TIMEOUT_RST;
      security_delay_r  <= dsst_pkg::SECURITY_DELAY_RST;
      max_invalid_r     <= dsst_pkg::MAX_INVALID_RST;
      reset_delay_r     <= dsst_pkg::RESET_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        dsst_pkg::REG_SESSION_TIMEOUT: session_timeout_r <= cfg_wdata;
        dsst_pkg::REG_SECURITY_DELAY:  security_delay_r  <= cfg_wdata;
        dsst_pkg::REG_MAX_INVALID:     max_invalid_r     <= cfg_wdata[7:0];
        dsst_pkg::REG_RESET_DELAY:     reset_delay_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // session state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_r       <= dsst_pkg::SES_STD;
      session_timer_r <= TIMER_BITS'(dsst_pkg::SESSION_TIMEOUT_RST);
      fail_count_r    <= 8'd0;
      delay_timer_r   <= TIMER_BITS'(dsst_pkg::SECURITY_DELAY_RST);
      delay_flag_r    <= 1'b0;
      reset_armed_r   <= 1'b0;
      reset_timer_r   <= '0;
      reset_flag_r    <= 1'b0;
      prog_flag_r     <= 1'b0;
    end else if (step) begin
      session_r       <= session_nxt;
      session_timer_r <= session_timer_nxt;
      fail_count_r    <= fail_count_nxt;
      delay_timer_r   <= delay_timer_nxt;
      delay_flag_r    <= delay_flag_nxt;
      reset_armed_r   <= reset_armed_nxt;
      reset_timer_r   <= reset_timer_nxt;
      reset_flag_r    <= reset_flag_nxt;
      prog_flag_r     <= prog_flag_nxt;
    end
  end

  assign result.reply_code           = rsp;
  assign result.session              = session_nxt;
  assign result.access_delayed       = delay_flag_nxt;
  assign result.reset_request_flag   = reset_flag_nxt;
  assign result.prog_request_pending = prog_flag_nxt;
  assign result.reset_due            = due;

  a_no_prog_session: assert property (@(posedge clk) disable iff (!rst_n)
    session_r != dsst_pkg::SES_PROG)
    else $error("programming session entered");

  a_due_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    step && due |-> item.command == dsst_pkg::CMD_TICK && reset_armed_r)
    else $error("reset due outside a tick");

  a_fail_limit: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.command == dsst_pkg::CMD_FAIL_UNLOCK
    |=> delay_flag_r || (fail_count_r < $past(max_invalid_r)))
    else $error("fail limit reached without access delay");

endmodule
`default_nettype wire

FILE: rtl/diag_session_security_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diag_session_security_timer: diagnostic session keeper
// Words arrive on the in_ stream: a tick, a session request, a failed
// unlock, an ecu reset request or a reset flag write. Each word yields
// exactly one result word on the out_ stream with the reply code and
// the session, access delay, reset request, programming pending and
// reset due state after that word.
// A word taken on in_ is held in an input register, updated against the
// state and placed in the output register, from which its result is
// offered on out_. One word per cycle is sustained while out_tready
// stays high; the state update loop sets that rate.
// The cfg_ port writes the four registers at any edge with cfg_we high;
// writes take effect on the next word and do not reload running timers.
// Reset (rst_n low, synchronous) restores register defaults, standard
// session and cleared flags, and empties both registers.
// When out_tready is low the result holds, one more word may wait in the
// input register, and in_tready then drops until the result is taken.
// ----------------------------------------------------------------------------
module diag_session_security_timer #(
  parameter int TIMER_BITS = dsst_pkg::TIMER_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [dsst_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
  input  wire logic [dsst_pkg::CFG_WIDTH-1:0]      cfg_wdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // command[2:0], requested_session[4:3], flag_value[5], zero[7:6]
  input  wire logic [7:0]                          in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // reply_code[0], session[2:1], access_delayed[3],
  // reset_request_flag[4], prog_request_pending[5], reset_due[6], zero[7]
  output logic [7:0]                               out_tdata
);

  logic              in_valid_r;
  dsst_pkg::item_t   in_item_r;
  logic              out_valid_r;
  dsst_pkg::result_t out_res_r;
  dsst_pkg::result_t res;
  logic              advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.command           <= in_tdata[2:0];
      in_item_r.requested_session <= in_tdata[4:3];
      in_item_r.flag_value        <= in_tdata[5];
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  dsst_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (in_item_r),
    .result    (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.reset_due, out_res_r.prog_request_pending,
                       out_res_r.reset_request_flag, out_res_r.access_delayed,
                       out_res_r.session, out_res_r.reply_code};

endmodule
`default_nettype wire
